FILE: rtl/dhas_pkg.sv
// ----------------------------------------------------------------------------
// dhas_pkg: shared types and constants
// Widths, register indexes and payload structs for the decimating high pass
// audio stream block.
// ----------------------------------------------------------------------------
package dhas_pkg;

  localparam int BATCH_LEN   = 64;
  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;

  localparam int SUM_BITS     = 40;
  localparam int MEAN_BITS    = 24;
  localparam int FILT_BITS    = 32;
  localparam int TIME_BITS    = 64;
  localparam int PERIOD_BITS  = 24;
  localparam int COEFF_BITS   = 15;
  localparam int WEIGHT_BITS  = 16;
  localparam int INDEX_BITS   = 6;
  localparam int FILL_BITS    = $clog2(BATCH_LEN + 1);
  localparam int NUM_LANES    = 2;

  // Divider retires this many quotient bits per cycle.
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_ITERS      = SUM_BITS / DIV_RADIX_BITS;
  localparam int DIV_CNT_BITS   = $clog2(DIV_ITERS);

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT = 2'd3;

  localparam logic [PERIOD_BITS-1:0] RST_PERIOD = 24'd20833;
  localparam logic [COEFF_BITS-1:0]  RST_COEFF  = 15'd32597;
  localparam logic [WEIGHT_BITS-1:0] RST_WEIGHT = 16'd1311;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  typedef struct packed {
    logic [TIME_BITS-1:0]          step_time_ns;
    logic signed [MEAN_BITS-1:0]   torque_sample;
    logic signed [MEAN_BITS-1:0]   current_sample;
    logic                          restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] audio_value;
    logic [TIME_BITS-1:0]          batch_start_ns;
    logic [INDEX_BITS-1:0]         sample_index;
    logic                          last_of_batch;
  } out_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  batch_start_ns;
    logic [INDEX_BITS-1:0] sample_index;
    logic                  last_of_batch;
  } tag_t;

  typedef struct packed {
    logic                        start;
    logic signed [FILT_BITS-1:0] y_torque;
    logic signed [FILT_BITS-1:0] y_current;
    logic [WEIGHT_BITS-1:0]      weight;
    tag_t                        tag;
  } merge_req_t;

  function automatic logic signed [SUM_BITS-1:0] sat_sum(input logic signed [SUM_BITS:0] v);
    logic signed [SUM_BITS-1:0] r;
    if (v > (SUM_BITS+1)'(SUM_MAX)) begin
      r = SUM_MAX;
    end else if (v < (SUM_BITS+1)'(SUM_MIN)) begin
      r = SUM_MIN;
    end else begin
      r = SUM_BITS'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/dhas_div.sv
// ----------------------------------------------------------------------------
// dhas_div: iterative sum-by-count divider
// Restoring division of the magnitude of a signed sum by an unsigned count,
// two quotient bits per cycle. The sign is returned beside the magnitude.
// ----------------------------------------------------------------------------
module dhas_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [dhas_pkg::SUM_BITS-1:0] dividend,
  input  logic [dhas_pkg::COUNT_BITS-1:0]     divisor,
  output logic                                done,
  output logic [dhas_pkg::SUM_BITS-1:0]       quot_mag,
  output logic                                quot_neg
);
  import dhas_pkg::*;

  localparam int REM_BITS = COUNT_BITS + 1;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [SUM_BITS-1:0]     num;
  logic [SUM_BITS-1:0]     num_next;
  logic [REM_BITS-1:0]     rem;
  logic [REM_BITS-1:0]     rem_next;
  logic [COUNT_BITS-1:0]   den;
  logic                    neg;

  always_comb begin
    logic [REM_BITS-1:0] r;
    logic [SUM_BITS-1:0] n;
    r = rem;
    n = num;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      r = {r[REM_BITS-2:0], n[SUM_BITS-1]};
      n = {n[SUM_BITS-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        n[0] = 1'b1;
      end
    end
    rem_next = r;
    num_next = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(DIV_ITERS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
      neg <= dividend[SUM_BITS-1];
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign quot_mag = num;
  assign quot_neg = neg;

endmodule

FILE: rtl/dhas_lane.sv
// ----------------------------------------------------------------------------
// dhas_lane: one channel of mean and high pass
// Divides the channel sum by the step count, clamps the mean to 24 bits and
// runs it through the one-pole high pass y = a * (y + x - x_prev).
// ----------------------------------------------------------------------------
module dhas_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [dhas_pkg::SUM_BITS-1:0]  sum,
  input  logic [dhas_pkg::COUNT_BITS-1:0]      count,
  input  logic [dhas_pkg::COEFF_BITS-1:0]      coeff,
  output logic                                 done,
  output logic signed [dhas_pkg::FILT_BITS-1:0] y
);
  import dhas_pkg::*;

  localparam int DIFF_BITS = FILT_BITS + 2;
  localparam int PROD_BITS = DIFF_BITS + COEFF_BITS + 1;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_DIV  = 3'd1;
  localparam logic [2:0] L_MUL  = 3'd2;
  localparam logic [2:0] L_RND  = 3'd3;

  localparam logic [SUM_BITS-1:0] MEAN_POS_LIM = SUM_BITS'((64'd1 << (MEAN_BITS - 1)) - 1);
  localparam logic [SUM_BITS-1:0] MEAN_NEG_LIM = SUM_BITS'(64'd1 << (MEAN_BITS - 1));

  logic [2:0]                  state;
  logic                        div_done;
  logic [SUM_BITS-1:0]         quot_mag;
  logic                        quot_neg;
  logic                        zero_count;
  logic signed [MEAN_BITS-1:0] mean;
  logic signed [MEAN_BITS-1:0] mean_next;
  logic signed [FILT_BITS-1:0] filter_out;
  logic signed [MEAN_BITS-1:0] prev_in;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] prod_rnd;
  logic signed [FILT_BITS-1:0] y_next;

  dhas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quot_mag (quot_mag),
    .quot_neg (quot_neg)
  );

  // Truncated quotient with sign applied, clamped to the 24-bit mean range.
  always_comb begin
    if (zero_count) begin
      mean_next = '0;
    end else if (!quot_neg && quot_mag > MEAN_POS_LIM) begin
      mean_next = {1'b0, {(MEAN_BITS-1){1'b1}}};
    end else if (quot_neg && quot_mag > MEAN_NEG_LIM) begin
      mean_next = {1'b1, {(MEAN_BITS-1){1'b0}}};
    end else if (quot_neg) begin
      mean_next = MEAN_BITS'(~quot_mag + 1'b1);
    end else begin
      mean_next = MEAN_BITS'(quot_mag);
    end
  end

  assign diff     = DIFF_BITS'(filter_out) + DIFF_BITS'(mean) - DIFF_BITS'(prev_in);
  assign prod_rnd = (prod + PROD_BITS'(64'sd16384)) >>> COEFF_BITS;

  always_comb begin
    if (prod_rnd > PROD_BITS'(64'sd2147483647)) begin
      y_next = {1'b0, {(FILT_BITS-1){1'b1}}};
    end else if (prod_rnd < -PROD_BITS'(64'sd2147483648)) begin
      y_next = {1'b1, {(FILT_BITS-1){1'b0}}};
    end else begin
      y_next = FILT_BITS'(prod_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= L_IDLE;
      done       <= 1'b0;
      filter_out <= '0;
      prev_in    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            state <= L_DIV;
          end
        end
        L_DIV: begin
          if (div_done) begin
            state <= L_MUL;
          end
        end
        L_MUL: begin
          state <= L_RND;
        end
        L_RND: begin
          filter_out <= y_next;
          prev_in    <= mean;
          done       <= 1'b1;
          state      <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_count <= (count == '0);
    end
    if (state == L_DIV && div_done) begin
      mean <= mean_next;
    end
    if (state == L_MUL) begin
      prod <= PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, coeff}));
    end
  end

  assign y = filter_out;

endmodule

FILE: rtl/dhas_merge.sv
// ----------------------------------------------------------------------------
// dhas_merge: channel combine and output register
// Weights the current channel, adds the torque channel, saturates to the
// sample width and holds the result for the output transfer.
// ----------------------------------------------------------------------------
module dhas_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  dhas_pkg::merge_req_t req,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dhas_pkg::out_item_t  out_item
);
  import dhas_pkg::*;

  localparam int WPROD_BITS = FILT_BITS + WEIGHT_BITS + 1;
  localparam int ACC_BITS   = FILT_BITS + 2;

  localparam logic signed [ACC_BITS-1:0] AUD_MAX =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] AUD_MIN =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic                           pend;
  logic signed [FILT_BITS-1:0]    y0;
  logic signed [WPROD_BITS-1:0]   wprod;
  tag_t                           tag;
  logic signed [WPROD_BITS-1:0]   wterm;
  logic signed [ACC_BITS-1:0]     acc;
  logic signed [SAMPLE_BITS-1:0]  audio;
  logic                           load_out;

  assign wterm    = (wprod + WPROD_BITS'(64'sd32768)) >>> WEIGHT_BITS;
  assign acc      = ACC_BITS'(y0) + ACC_BITS'(wterm);
  assign load_out = pend && (!out_valid || !out_stall);

  always_comb begin
    if (acc > AUD_MAX) begin
      audio = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (acc < AUD_MIN) begin
      audio = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      audio = SAMPLE_BITS'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.start) begin
        pend <= 1'b1;
      end else if (load_out) begin
        pend <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      y0    <= req.y_torque;
      wprod <= WPROD_BITS'(req.y_current) * WPROD_BITS'($signed({1'b0, req.weight}));
      tag   <= req.tag;
    end
    if (load_out) begin
      out_item.audio_value    <= audio;
      out_item.batch_start_ns <= tag.batch_start_ns;
      out_item.sample_index   <= tag.sample_index;
      out_item.last_of_batch  <= tag.last_of_batch;
    end
  end

  assign busy = pend;

endmodule

FILE: rtl/decimating_highpass_audio_stream_top.sv
// ----------------------------------------------------------------------------
// decimating_highpass_audio_stream_top: boxcar decimator with high pass
// Accumulates torque and current steps, and at each deadline emits one
// filtered, weighted audio sample tagged with its batch position.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in      | in        | in_valid/in_stall  | in_item  (in_item_t)
//   out     | out       | out_valid/out_stall| out_item (out_item_t)
//   cfg     | in        | cfg_write          | cfg_index, cfg_data
//
// A step that produces no sample does not stall the input. After a step that
// reaches its deadline the next step waits for the two-bit-per-cycle divider
// in each lane, then the filter multiply and round, then the merge. It waits
// longer while an earlier sample is still held in the merge stage behind a
// stalled output.
// Results wait in the output register while the next steps are taken.
// Reset is synchronous; it restores the register defaults and clears all
// sums, filter state, batch position and deadline.
// ----------------------------------------------------------------------------
module decimating_highpass_audio_stream_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dhas_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output dhas_pkg::out_item_t                   out_item,
  input  logic                                  cfg_write,
  input  logic [dhas_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dhas_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import dhas_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LANE  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  logic [1:0]                  state;
  logic                        enable;
  logic [PERIOD_BITS-1:0]      out_period;
  logic [COEFF_BITS-1:0]       hpf_coeff;
  logic [WEIGHT_BITS-1:0]      current_weight;

  logic signed [SUM_BITS-1:0]  torque_sum;
  logic signed [SUM_BITS-1:0]  current_sum;
  logic [COUNT_BITS-1:0]       step_count;
  logic [TIME_BITS-1:0]        next_deadline;
  logic [FILL_BITS-1:0]        batch_fill;
  logic [TIME_BITS-1:0]        batch_time;
  tag_t                        tag;

  logic                        accept;
  logic signed [SUM_BITS-1:0]  torque_base;
  logic signed [SUM_BITS-1:0]  current_base;
  logic [COUNT_BITS-1:0]       count_base;
  logic [TIME_BITS-1:0]        deadline_base;
  logic [FILL_BITS-1:0]        fill_base;
  logic signed [SUM_BITS-1:0]  torque_sum_next;
  logic signed [SUM_BITS-1:0]  current_sum_next;
  logic [COUNT_BITS-1:0]       step_count_next;
  logic                        emit;
  logic [TIME_BITS-1:0]        tag_time;
  logic [FILL_BITS-1:0]        fill_inc;
  logic                        fill_last;

  logic                        lane_start;
  logic signed [SUM_BITS-1:0]  lane_sum  [NUM_LANES];
  logic                        lane_done [NUM_LANES];
  logic signed [FILT_BITS-1:0] lane_y    [NUM_LANES];
  merge_req_t                  merge_req;
  logic                        merge_busy;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Restart clears the running state before the step is applied.
  assign torque_base   = in_item.restart ? '0 : torque_sum;
  assign current_base  = in_item.restart ? '0 : current_sum;
  assign count_base    = in_item.restart ? '0 : step_count;
  assign deadline_base = in_item.restart ? '0 : next_deadline;
  assign fill_base     = in_item.restart ? '0 : batch_fill;

  assign torque_sum_next  = sat_sum((SUM_BITS+1)'(torque_base) +
                                    (SUM_BITS+1)'(in_item.torque_sample));
  assign current_sum_next = sat_sum((SUM_BITS+1)'(current_base) +
                                    (SUM_BITS+1)'(in_item.current_sample));
  assign step_count_next  = (count_base == '1) ? count_base : count_base + 1'b1;

  assign emit       = enable && !(in_item.step_time_ns < deadline_base);
  assign lane_start = accept && emit;
  assign tag_time   = (fill_base == '0) ? in_item.step_time_ns : batch_time;
  assign fill_inc   = fill_base + 1'b1;
  assign fill_last  = (fill_inc >= FILL_BITS'(BATCH_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      out_period     <= RST_PERIOD;
      hpf_coeff      <= RST_COEFF;
      current_weight <= RST_WEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE: enable         <= cfg_data[0];
        REG_PERIOD: out_period     <= cfg_data[PERIOD_BITS-1:0];
        REG_COEFF:  hpf_coeff      <= cfg_data[COEFF_BITS-1:0];
        REG_WEIGHT: current_weight <= cfg_data[WEIGHT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      torque_sum    <= '0;
      current_sum   <= '0;
      step_count    <= '0;
      next_deadline <= '0;
      batch_fill    <= '0;
      batch_time    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!enable) begin
              torque_sum    <= torque_base;
              current_sum   <= current_base;
              step_count    <= count_base;
              next_deadline <= deadline_base;
              batch_fill    <= fill_base;
            end else if (!emit) begin
              torque_sum    <= torque_sum_next;
              current_sum   <= current_sum_next;
              step_count    <= step_count_next;
              next_deadline <= deadline_base;
              batch_fill    <= fill_base;
            end else begin
              torque_sum    <= '0;
              current_sum   <= '0;
              step_count    <= '0;
              next_deadline <= in_item.step_time_ns + TIME_BITS'(out_period);
              batch_time    <= tag_time;
              batch_fill    <= fill_last ? '0 : fill_inc;
              state         <= ST_LANE;
            end
          end
        end
        ST_LANE: begin
          if (lane_done[0]) begin
            state <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (!merge_busy) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (lane_start) begin
      tag.batch_start_ns <= tag_time;
      tag.sample_index   <= INDEX_BITS'(fill_base);
      tag.last_of_batch  <= fill_last;
    end
  end

  assign lane_sum[0] = torque_sum_next;
  assign lane_sum[1] = current_sum_next;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    dhas_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start),
      .sum   (lane_sum[g]),
      .count (step_count_next),
      .coeff (hpf_coeff),
      .done  (lane_done[g]),
      .y     (lane_y[g])
    );
  end

  assign merge_req.start     = (state == ST_MERGE) && !merge_busy;
  assign merge_req.y_torque  = lane_y[0];
  assign merge_req.y_current = lane_y[1];
  assign merge_req.weight    = current_weight;
  assign merge_req.tag       = tag;

  dhas_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .req       (merge_req),
    .busy      (merge_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Both lanes run the same fixed schedule and must finish together.
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] == lane_done[1])
    else $error("channel lanes finished on different cycles");

  a_done_in_lane_state: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> state == ST_LANE)
    else $error("lane finished outside the lane wait state");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    batch_fill < FILL_BITS'(BATCH_LEN))
    else $error("batch position ran past the batch length");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last_of_batch) |->
      out_item.sample_index == INDEX_BITS'(BATCH_LEN - 1))
    else $error("last sample of a batch carries the wrong index");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for decimating_highpass_audio_stream_top
// Sends physics steps and register writes to the block. A behavioral copy of
// the accumulate, divide, high pass and merge path predicts each audio sample,
// and every output transfer is compared with the oldest prediction, field by
// field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dhas_pkg::*;

  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_STEPS   = 850;
  localparam int QUIET_FROM     = 720;
  localparam int SOAK_STEPS     = 40;
  localparam int MAX_PRINTS     = 60;

  localparam longint MEAN_HI = 64'sd8388607;
  localparam longint MEAN_LO = -64'sd8388608;
  localparam longint FILT_HI = 64'sd2147483647;
  localparam longint FILT_LO = -64'sd2147483648;
  localparam longint ACC_HI  = longint'(SUM_MAX);
  localparam longint ACC_LO  = longint'(SUM_MIN);
  localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;

  localparam logic [MEAN_BITS-1:0] POS_FULL = 24'h7FFFFF;
  localparam logic [MEAN_BITS-1:0] NEG_FULL = 24'h800000;

  typedef enum logic [0:0] {DIR_CFG, DIR_STEP} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} row_check_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] reg_idx;
    logic [CFG_DATA_BITS-1:0]  reg_data;
    in_item_t                  step;
    row_check_t                check;
    out_item_t                 given;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  in_item_t                  in_item = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_item_t                 out_item;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  bit        idle_on = 1'b0;
  int        errors = 0;
  int        stall_cycles = 0;
  out_item_t expected_audio[$];
  dir_row_t  dir_rows[$];

  // Mirror of the block's registers and state, at their reset values.
  logic                   m_en = 1'b0;
  logic [PERIOD_BITS-1:0] m_period = RST_PERIOD;
  logic [COEFF_BITS-1:0]  m_coeff = RST_COEFF;
  logic [WEIGHT_BITS-1:0] m_weight = RST_WEIGHT;
  longint                 m_tq_sum = 0;
  longint                 m_cu_sum = 0;
  int unsigned            m_count = 0;
  logic [TIME_BITS-1:0]   m_deadline = '0;
  longint                 m_y[NUM_LANES] = '{0, 0};
  longint                 m_x[NUM_LANES] = '{0, 0};
  int unsigned            m_fill = 0;
  logic [TIME_BITS-1:0]   m_batch_t = '0;

  decimating_highpass_audio_stream_top DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint hp_filter(int k, longint x);
    longint y;
    y = ((m_y[k] + x - m_x[k]) * longint'(m_coeff) + 64'sd16384) >>> 15;
    y = clamp(y, FILT_LO, FILT_HI);
    m_y[k] = y;
    m_x[k] = x;
    return y;
  endfunction

  function automatic void predict_audio(input in_item_t st, output bit emits,
                                        output out_item_t smp);
    longint      y0;
    longint      y1;
    longint      s;
    int unsigned idx;
    emits = 1'b0;
    smp = '0;
    if (st.restart) begin
      m_tq_sum = 0;
      m_cu_sum = 0;
      m_count = 0;
      m_fill = 0;
      m_deadline = '0;
    end
    if (!m_en) return;
    m_tq_sum = clamp(m_tq_sum + longint'($signed(st.torque_sample)), ACC_LO, ACC_HI);
    m_cu_sum = clamp(m_cu_sum + longint'($signed(st.current_sample)), ACC_LO, ACC_HI);
    if (m_count < COUNT_MAX) m_count++;
    if (st.step_time_ns < m_deadline) return;
    m_deadline = st.step_time_ns + TIME_BITS'(m_period);
    // Division truncates toward zero, as signed longint division does.
    y0 = hp_filter(0, clamp(m_tq_sum / longint'(m_count), MEAN_LO, MEAN_HI));
    y1 = hp_filter(1, clamp(m_cu_sum / longint'(m_count), MEAN_LO, MEAN_HI));
    m_tq_sum = 0;
    m_cu_sum = 0;
    m_count = 0;
    s = y0 + ((y1 * longint'(m_weight) + 64'sd32768) >>> 16);
    s = clamp(s, MEAN_LO, MEAN_HI);
    if (m_fill == 0) m_batch_t = st.step_time_ns;
    idx = m_fill;
    m_fill++;
    smp.audio_value = s[SAMPLE_BITS-1:0];
    smp.batch_start_ns = m_batch_t;
    smp.sample_index = idx[INDEX_BITS-1:0];
    smp.last_of_batch = (m_fill >= BATCH_LEN);
    if (m_fill >= BATCH_LEN) m_fill = 0;
    emits = 1'b1;
  endfunction

  function automatic void mirror_cfg(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_ENABLE: m_en = data[0];
      REG_PERIOD: m_period = data[PERIOD_BITS-1:0];
      REG_COEFF:  m_coeff = data[COEFF_BITS-1:0];
      REG_WEIGHT: m_weight = data[WEIGHT_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk_step(logic [TIME_BITS-1:0] t, logic [MEAN_BITS-1:0] tq,
                                       logic [MEAN_BITS-1:0] cu, logic rs);
    in_item_t st;
    st.step_time_ns = t;
    st.torque_sample = tq;
    st.current_sample = cu;
    st.restart = rs;
    return st;
  endfunction

  function automatic out_item_t mk_sample(logic [SAMPLE_BITS-1:0] v, logic [TIME_BITS-1:0] bt,
                                          logic [INDEX_BITS-1:0] idx, logic last);
    out_item_t smp;
    smp.audio_value = v;
    smp.batch_start_ns = bt;
    smp.sample_index = idx;
    smp.last_of_batch = last;
    return smp;
  endfunction

  function automatic void add_cfg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    dir_row_t r;
    r.kind = DIR_CFG;
    r.reg_idx = idx;
    r.reg_data = data;
    r.step = '0;
    r.check = EXP_NONE;
    r.given = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_step(in_item_t st, row_check_t check, out_item_t given);
    dir_row_t r;
    r.kind = DIR_STEP;
    r.reg_idx = '0;
    r.reg_data = '0;
    r.step = st;
    r.check = check;
    r.given = given;
    dir_rows.push_back(r);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_sample(out_item_t got, out_item_t want);
    if (got.audio_value !== want.audio_value)
      report_mismatch($sformatf("audio_value got %0d expected %0d",
                                $signed(got.audio_value), $signed(want.audio_value)));
    if (got.batch_start_ns !== want.batch_start_ns)
      report_mismatch($sformatf("batch_start_ns got %0h expected %0h",
                                got.batch_start_ns, want.batch_start_ns));
    if (got.sample_index !== want.sample_index)
      report_mismatch($sformatf("sample_index got %0d expected %0d",
                                got.sample_index, want.sample_index));
    if (got.last_of_batch !== want.last_of_batch)
      report_mismatch($sformatf("last_of_batch got %0b expected %0b",
                                got.last_of_batch, want.last_of_batch));
  endtask

  // Register writes only go out once the block has drained.
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    in_valid <= 1'b0;
    while (expected_audio.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    mirror_cfg(idx, data);
  endtask

  // Leaves in_valid high after the transfer; the caller lowers it when done.
  task automatic send_step(in_item_t st, row_check_t check, out_item_t given);
    bit        emits;
    out_item_t smp;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= st;
    do @(posedge clk); while (in_stall);
    predict_audio(st, emits, smp);
    case (check)
      EXP_MODEL: if (emits) expected_audio.push_back(smp);
      EXP_GIVEN: expected_audio.push_back(given);
      default: ;
    endcase
  endtask

  initial begin
    int unsigned left;
    left = 0;
    forever begin
      @(posedge clk);
      if (left != 0) left--;
      else if (idle_on && $urandom_range(0, 5) == 0) left = $urandom_range(1, 12);
      out_stall <= (left != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_audio.size() == 0)
        report_mismatch($sformatf("unexpected sample, audio_value %0d",
                                  $signed(out_item.audio_value)));
      else
        check_sample(out_item, expected_audio.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [TIME_BITS-1:0]   t_now;
    logic [PERIOD_BITS-1:0] period;
    logic [COEFF_BITS-1:0]  coeff;
    logic [WEIGHT_BITS-1:0] weight;
    logic [MEAN_BITS-1:0]   tq;
    logic [MEAN_BITS-1:0]   cu;
    int unsigned            stride;
    int unsigned            len;
    int                     active;
    bit                     en;
    bit                     rs_first;
    bit                     swing;

    // Defaults after reset: disabled, period 20833, coefficient 32597.
    add_step(mk_step(64'd5, POS_FULL, NEG_FULL, 1'b0), EXP_NONE, '0);
    add_cfg(REG_ENABLE, 24'hFFFFFF);
    add_step(mk_step(64'd0, 24'd0, 24'd0, 1'b0), EXP_GIVEN, mk_sample(24'd0, 64'd0, 6'd0, 1'b0));
    add_step(mk_step(64'd1000, POS_FULL, POS_FULL, 1'b0), EXP_NONE, '0);
    add_step(mk_step(64'd20833, POS_FULL, POS_FULL, 1'b0), EXP_MODEL, '0);
    // The deadline after the all-ones timestamp wraps around to 20832.
    add_step(mk_step(64'hFFFF_FFFF_FFFF_FFFF, NEG_FULL, NEG_FULL, 1'b0), EXP_MODEL, '0);
    add_step(mk_step(64'd20000, NEG_FULL, POS_FULL, 1'b0), EXP_NONE, '0);
    add_step(mk_step(64'd20832, 24'd1, 24'hFFFFFF, 1'b0), EXP_MODEL, '0);
    add_step(mk_step(64'd7, 24'd0, 24'd0, 1'b1), EXP_MODEL, '0);
    // A restart still takes effect while the block is disabled.
    add_cfg(REG_ENABLE, 24'hFFFFFE);
    add_step(mk_step(64'd99, POS_FULL, POS_FULL, 1'b1), EXP_NONE, '0);
    add_cfg(REG_ENABLE, 24'd1);
    add_cfg(REG_PERIOD, 24'd0);
    add_cfg(REG_COEFF, 24'hFF8000);
    // With a zero coefficient the filter output, and so the sample, is zero.
    add_step(mk_step(64'd500, POS_FULL, POS_FULL, 1'b0), EXP_GIVEN,
             mk_sample(24'd0, 64'd500, 6'd0, 1'b0));
    add_step(mk_step(64'd500, NEG_FULL, POS_FULL, 1'b0), EXP_GIVEN,
             mk_sample(24'd0, 64'd500, 6'd1, 1'b0));
    add_cfg(REG_COEFF, 24'hFFFFFF);
    add_cfg(REG_WEIGHT, 24'hFFFFFF);
    add_step(mk_step(64'd501, POS_FULL, POS_FULL, 1'b0), EXP_MODEL, '0);
    add_step(mk_step(64'd502, NEG_FULL, NEG_FULL, 1'b0), EXP_MODEL, '0);
    add_step(mk_step(64'd503, 24'd1, 24'hFFFFFF, 1'b0), EXP_MODEL, '0);
    add_cfg(REG_WEIGHT, 24'hFF0000);
    add_step(mk_step(64'd504, NEG_FULL, POS_FULL, 1'b0), EXP_MODEL, '0);
    add_cfg(REG_PERIOD, 24'hFFFFFF);
    add_step(mk_step(64'd505, POS_FULL, NEG_FULL, 1'b0), EXP_MODEL, '0);
    add_step(mk_step(64'd506, 24'h123456, 24'hABCDEF, 1'b0), EXP_MODEL, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == DIR_CFG) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      else send_step(dir_rows[i].step, dir_rows[i].check, dir_rows[i].given);
    end

    // Run of full-scale steps under one long deadline, so the sample is the
    // mean of many accumulated steps.
    write_reg(REG_WEIGHT, 24'd1311);
    send_step(mk_step(64'd0, POS_FULL, NEG_FULL, 1'b1), EXP_MODEL, '0);
    for (int i = 1; i <= SOAK_STEPS; i++)
      send_step(mk_step(TIME_BITS'(i), POS_FULL, NEG_FULL, 1'b0), EXP_MODEL, '0);
    send_step(mk_step(64'hFF_FFFF, POS_FULL, NEG_FULL, 1'b0), EXP_MODEL, '0);

    t_now = '0;
    active = 0;
    while (active < RANDOM_STEPS) begin
      idle_on = (active < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      en = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 5))
        0: period = '0;
        1: period = PERIOD_BITS'($urandom_range(1, 40));
        2: period = PERIOD_BITS'($urandom_range(41, 5000));
        3: period = 24'hFFFFFF;
        4: period = RST_PERIOD;
        default: period = PERIOD_BITS'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: coeff = '0;
        1: coeff = 15'h7FFF;
        default: coeff = COEFF_BITS'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: weight = '0;
        1: weight = 16'hFFFF;
        default: weight = WEIGHT_BITS'($urandom);
      endcase
      // Upper data bits carry junk that the register must drop.
      write_reg(REG_ENABLE, (CFG_DATA_BITS'($urandom) & ~24'h1) | CFG_DATA_BITS'(en));
      write_reg(REG_PERIOD, period);
      write_reg(REG_COEFF, (CFG_DATA_BITS'($urandom) & ~24'h7FFF) | CFG_DATA_BITS'(coeff));
      write_reg(REG_WEIGHT, (CFG_DATA_BITS'($urandom) & ~24'hFFFF) | CFG_DATA_BITS'(weight));

      case ($urandom_range(0, 5))
        0: begin
          t_now = {$urandom, $urandom};
          rs_first = 1'b1;
        end
        1: begin
          t_now = 64'hFFFF_FFFF_FFFF_FFFF - TIME_BITS'($urandom_range(0, 4 * period + 8));
          rs_first = 1'b1;
        end
        default: rs_first = ($urandom_range(0, 2) == 0);
      endcase
      stride = (period == 0) ? 100 : 32'(period) * 2 / 3 + 1;
      swing = ($urandom_range(0, 5) == 0);
      len = $urandom_range(60, 120);

      for (int k = 0; k < len; k++) begin
        if (active >= QUIET_FROM) idle_on = 1'b0;
        // Now and then the timestamp jumps anywhere, backward included.
        if ($urandom_range(0, 49) == 0) t_now = {$urandom, $urandom};
        else t_now = t_now + TIME_BITS'($urandom_range(0, stride));
        if (swing) begin
          tq = k[0] ? NEG_FULL : POS_FULL;
          cu = k[0] ? POS_FULL : NEG_FULL;
        end else begin
          case ($urandom_range(0, 9))
            0: begin
              tq = $urandom_range(0, 1) ? POS_FULL : NEG_FULL;
              cu = $urandom_range(0, 1) ? POS_FULL : NEG_FULL;
            end
            1: begin
              tq = MEAN_BITS'($urandom_range(0, 255)) - 24'd128;
              cu = MEAN_BITS'($urandom_range(0, 255)) - 24'd128;
            end
            default: begin
              tq = MEAN_BITS'($urandom);
              cu = MEAN_BITS'($urandom);
            end
          endcase
        end
        send_step(mk_step(t_now, tq, cu, (k == 0 && rs_first) || ($urandom_range(0, 199) == 0)),
                  EXP_MODEL, '0);
        active++;
      end
    end

    in_valid <= 1'b0;
    idle_on = 1'b0;
    while (expected_audio.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
